// ===== rtl/sfap_pkg.sv =====
// shared types and constants for the steering block
// no dependencies; imported by sfap_arith and the top level
package sfap_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int WP_AW = $clog2(MAX_WAYPOINTS);
    localparam int WP_CW = WP_AW + 1;

    // item commands
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SEEK   = 3'd1;
    localparam logic [2:0] CMD_FLEE   = 3'd2;
    localparam logic [2:0] CMD_ARRIVE = 3'd3;
    localparam logic [2:0] CMD_ADD    = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;
    localparam logic [2:0] CMD_PATROL = 3'd6;
    localparam logic [2:0] CMD_IDLE   = 3'd7;

    // steering modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_SEEK   = 3'd1;
    localparam logic [2:0] MODE_ARRIVE = 3'd2;
    localparam logic [2:0] MODE_FLEE   = 3'd3;
    localparam logic [2:0] MODE_PATROL = 3'd4;

    // entity kinds
    localparam logic [1:0] KIND_SPRITE = 2'd1;
    localparam logic [1:0] KIND_SHAPE  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SPEED  = 2'd0;
    localparam logic [1:0] REG_STOP   = 2'd1;
    localparam logic [1:0] REG_ARRIVE = 2'd2;
    localparam logic [1:0] REG_KIND   = 2'd3;

    // arithmetic unit operations
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_ROOT = 2'd2;

    localparam logic [32:0] FLEE_MIN_DIST = 33'd66;
    localparam logic [32:0] ONE_Q16       = 33'd65536;
    localparam logic [31:0] FLEE_REACH    = 32'd26214400;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [64:0] a;
        logic [32:0] b;
    } arith_req_t;

endpackage

// ===== rtl/sfap_ram.sv =====
// generic single write port, single read port memory with registered read
// no dependencies
module sfap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sfap_arith.sv =====
// shared arithmetic unit: registered multiply, bit-serial divide and square root
// depends on sfap_pkg
module sfap_arith (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfap_pkg::arith_req_t req,
    output logic                 done,
    output logic [65:0]          result
);
    import sfap_pkg::*;

    localparam logic [6:0] DIV_STEPS  = 7'd65;
    localparam logic [6:0] ROOT_STEPS = 7'd32;

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  op_reg;
    logic [6:0]  cnt_reg;
    logic [64:0] num_reg;
    logic [32:0] rem_reg;
    logic [32:0] den_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [65:0] result_reg;

    logic [33:0] div_trial;
    logic        div_ge;
    logic [33:0] div_diff;
    logic [32:0] div_rem_next;
    logic [64:0] div_num_next;
    logic [63:0] root_sum;
    logic        root_ge;
    logic [63:0] root_n_next;
    logic [63:0] root_r_next;

    // restoring divide, one quotient bit a cycle
    always_comb begin
        div_trial    = {rem_reg, num_reg[64]};
        div_ge       = div_trial >= {1'b0, den_reg};
        div_diff     = div_trial - {1'b0, den_reg};
        div_rem_next = div_ge ? div_diff[32:0] : div_trial[32:0];
        div_num_next = {num_reg[63:0], div_ge};
    end

    // digit-by-digit square root, one result bit a cycle
    always_comb begin
        root_sum    = root_reg + bit_reg;
        root_ge     = num_reg[63:0] >= root_sum;
        root_n_next = root_ge ? num_reg[63:0] - root_sum : num_reg[63:0];
        root_r_next = root_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                op_reg <= req.op;
                unique case (req.op)
                    OP_MUL: begin
                        result_reg <= {33'd0, req.a[32:0]} * {33'd0, req.b};
                        done_reg   <= 1'b1;
                    end
                    OP_DIV: begin
                        num_reg  <= req.a;
                        rem_reg  <= '0;
                        den_reg  <= req.b;
                        cnt_reg  <= DIV_STEPS;
                        busy_reg <= 1'b1;
                    end
                    OP_ROOT: begin
                        num_reg  <= req.a;
                        root_reg <= '0;
                        bit_reg  <= 64'd1 << 62;
                        cnt_reg  <= ROOT_STEPS;
                        busy_reg <= 1'b1;
                    end
                    default: begin
                        done_reg <= 1'b1;
                    end
                endcase
            end else if (busy_reg) begin
                if (op_reg == OP_DIV) begin
                    num_reg    <= div_num_next;
                    rem_reg    <= div_rem_next;
                    result_reg <= {1'b0, div_num_next};
                end else begin
                    num_reg[63:0] <= root_n_next;
                    root_reg      <= root_r_next;
                    bit_reg       <= bit_reg >> 2;
                    result_reg    <= {2'b0, root_r_next};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/steering_seek_flee_arrive_patrol_top.sv =====
// top level of the point-entity steering block: sequencer, state and ports
// depends on sfap_pkg, sfap_arith and sfap_ram
//
// Command items give no result; start patrol also reads the first waypoint
// from the memory. A tick item runs on one shared unit (33x33 multiplier,
// bit-serial divider of 65 steps, bit-serial square root of 32 steps) under a
// small sequencer: distance, arrive scaling, a speed step and each axis
// offset as the mode and kind need, and in patrol a waypoint check that loads
// the next waypoint once it is reached; a tick can also wait for the output
// register to free up. One item is worked on at a time; the result waits
// in an output register so the next item is taken meanwhile.
// Waypoints live in a 16-entry memory that needs no clearing after reset.
module steering_seek_flee_arrive_patrol_top (
    input  logic               aclk,
    input  logic               aresetn,
    // input item channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_live_x,
    input  logic signed [31:0] s_live_y,
    input  logic               s_follow_live,
    input  logic [15:0]        s_frame_time,
    // result item channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_dest_x,
    output logic signed [31:0] m_dest_y,
    output logic               m_has_arrived,
    output logic [2:0]         m_current_mode,
    output logic [3:0]         m_waypoint_now,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sfap_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LOAD0    = 4'd1;
    localparam logic [3:0] ST_SQX      = 4'd2;
    localparam logic [3:0] ST_SQY      = 4'd3;
    localparam logic [3:0] ST_ROOT     = 4'd4;
    localparam logic [3:0] ST_DECIDE   = 4'd5;
    localparam logic [3:0] ST_ARRMUL   = 4'd6;
    localparam logic [3:0] ST_ARRDIV   = 4'd7;
    localparam logic [3:0] ST_STEP     = 4'd8;
    localparam logic [3:0] ST_OFFX_MUL = 4'd9;
    localparam logic [3:0] ST_OFFX_DIV = 4'd10;
    localparam logic [3:0] ST_OFFY_MUL = 4'd11;
    localparam logic [3:0] ST_OFFY_DIV = 4'd12;
    localparam logic [3:0] ST_PSETUP   = 4'd13;
    localparam logic [3:0] ST_WPLOAD   = 4'd14;
    localparam logic [3:0] ST_OUT      = 4'd15;

    localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
    localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

    // configuration registers
    logic [31:0] move_speed_reg;
    logic [31:0] stop_radius_reg;
    logic [31:0] arrive_radius_reg;
    logic [1:0]  entity_kind_reg;

    // steering state
    logic [3:0]         state_reg;
    logic [2:0]         mode_reg;
    logic signed [31:0] goal_x_reg;
    logic signed [31:0] goal_y_reg;
    logic               track_reg;
    logic               arrived_reg;
    logic [WP_CW-1:0]   wp_count_reg;
    logic [WP_AW-1:0]   wp_index_reg;

    // working registers of one tick
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic [15:0]        dt_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic [64:0]        acc_reg;
    logic [32:0]        dist_reg;
    logic [31:0]        spd_reg;
    logic [31:0]        step_reg;
    logic [31:0]        dest_x_reg;
    logic [31:0]        dest_y_reg;
    logic               check_reg;
    logic               go_reg;

    // result register
    logic               m_valid_reg;
    logic [31:0]        m_dest_x_reg;
    logic [31:0]        m_dest_y_reg;
    logic               m_arrived_reg;
    logic [2:0]         m_mode_reg;
    logic [WP_AW-1:0]   m_wp_reg;

    logic               accept;
    logic               cfg_write;
    logic               shape;
    logic               tick_live;
    logic [32:0]        mag_dx;
    logic [32:0]        mag_dy;
    logic [64:0]        root_arg;
    logic [32:0]        root_dist;
    logic [31:0]        step_new;
    logic [WP_CW-1:0]   idx_inc;
    logic [WP_AW-1:0]   idx_next;
    logic signed [31:0] gx_eff;
    logic signed [31:0] gy_eff;
    logic signed [31:0] ex;
    logic signed [31:0] ey;

    arith_req_t  req;
    logic        ar_done;
    logic [65:0] ar_result;

    logic                 wp_we;
    logic                 wp_re;
    logic [WP_AW-1:0]     wp_raddr;
    logic [63:0]          wp_rdata;

    // saturating cur +/- off into signed 32 bits
    function automatic logic [31:0] sat_move(input logic [31:0] cur, input logic neg,
                                             input logic [64:0] off);
        logic signed [66:0] base;
        logic signed [66:0] sum;
        base = {{35{cur[31]}}, cur};
        sum  = neg ? base - $signed({2'b0, off}) : base + $signed({2'b0, off});
        if (sum > SAT_MAX) begin
            return 32'h7fff_ffff;
        end else if (sum < SAT_MIN) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign shape     = (entity_kind_reg == KIND_SHAPE);

    // a tick does work only in a moving mode with something attached
    assign tick_live = ((mode_reg == MODE_SEEK) || (mode_reg == MODE_ARRIVE)
                        || (mode_reg == MODE_FLEE)
                        || ((mode_reg == MODE_PATROL) && (wp_count_reg != '0)))
                       && ((entity_kind_reg == KIND_SPRITE) || shape);

    // goal seen by this tick: live target when tracking
    assign gx_eff = track_reg ? s_live_x : goal_x_reg;
    assign gy_eff = track_reg ? s_live_y : goal_y_reg;

    // entity position for the patrol check
    assign ex = shape ? $signed(dest_x_reg) : px_reg;
    assign ey = shape ? $signed(dest_y_reg) : py_reg;

    assign mag_dx = dx_reg[32] ? 33'(-dx_reg) : dx_reg;
    assign mag_dy = dy_reg[32] ? 33'(-dy_reg) : dy_reg;

    // sum of squares beyond 64 bits is rooted at a quarter and doubled
    assign root_arg  = acc_reg[64] ? {2'b0, acc_reg[64:2]} : {1'b0, acc_reg[63:0]};
    assign root_dist = acc_reg[64] ? {ar_result[31:0], 1'b0} : {1'b0, ar_result[31:0]};
    assign step_new  = ar_result[47:16];

    // next waypoint, wrapping at the count
    assign idx_inc  = {1'b0, wp_index_reg} + 1'b1;
    assign idx_next = (idx_inc == wp_count_reg) ? '0 : idx_inc[WP_AW-1:0];

    // operand selection for the shared unit
    always_comb begin
        req.start = go_reg;
        req.op    = OP_MUL;
        req.a     = '0;
        req.b     = '0;
        case (state_reg)
            ST_SQX: begin
                req.a = {32'd0, mag_dx};
                req.b = mag_dx;
            end
            ST_SQY: begin
                req.a = {32'd0, mag_dy};
                req.b = mag_dy;
            end
            ST_ROOT: begin
                req.op = OP_ROOT;
                req.a  = root_arg;
            end
            ST_ARRMUL: begin
                req.a = {33'd0, move_speed_reg};
                req.b = dist_reg;
            end
            ST_ARRDIV: begin
                req.op = OP_DIV;
                req.a  = acc_reg;
                req.b  = {1'b0, arrive_radius_reg};
            end
            ST_STEP: begin
                req.a = {33'd0, spd_reg};
                req.b = {17'd0, dt_reg};
            end
            ST_OFFX_MUL: begin
                req.a = {32'd0, mag_dx};
                req.b = {1'b0, step_reg};
            end
            ST_OFFY_MUL: begin
                req.a = {32'd0, mag_dy};
                req.b = {1'b0, step_reg};
            end
            ST_OFFX_DIV, ST_OFFY_DIV: begin
                req.op = OP_DIV;
                req.a  = acc_reg;
                req.b  = dist_reg;
            end
            default: begin
                req.start = 1'b0;
            end
        endcase
    end

    sfap_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .done    (ar_done),
        .result  (ar_result)
    );

    // waypoint ring, x in the upper half of a word
    assign wp_we    = accept && (s_command == CMD_ADD)
                      && (wp_count_reg < WP_CW'(MAX_WAYPOINTS));
    assign wp_raddr = (state_reg == ST_IDLE) ? '0 : idx_next;
    assign wp_re    = (accept && (s_command == CMD_PATROL))
                      || ((state_reg == ST_ROOT) && ar_done);

    sfap_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WAYPOINTS)
    ) u_wp_ram (
        .aclk  (aclk),
        .we    (wp_we),
        .waddr (wp_count_reg[WP_AW-1:0]),
        .wdata ({s_pos_x, s_pos_y}),
        .re    (wp_re),
        .raddr (wp_raddr),
        .rdata (wp_rdata)
    );

    // configuration writes and reads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_speed_reg    <= 32'd6553600;
            stop_radius_reg   <= 32'd65536;
            arrive_radius_reg <= 32'd6553600;
            entity_kind_reg   <= 2'd0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_SPEED:  move_speed_reg    <= pwdata;
                REG_STOP:   stop_radius_reg   <= pwdata;
                REG_ARRIVE: arrive_radius_reg <= pwdata;
                REG_KIND:   entity_kind_reg   <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED:  prdata = move_speed_reg;
            REG_STOP:   prdata = stop_radius_reg;
            REG_ARRIVE: prdata = arrive_radius_reg;
            REG_KIND:   prdata = {30'd0, entity_kind_reg};
            default:    prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_IDLE;
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            track_reg    <= 1'b0;
            arrived_reg  <= 1'b0;
            wp_count_reg <= '0;
            wp_index_reg <= '0;
            go_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            // the output state reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (s_command)
                            CMD_TICK: begin
                                if (tick_live) begin
                                    if (track_reg) begin
                                        goal_x_reg <= s_live_x;
                                        goal_y_reg <= s_live_y;
                                    end
                                    px_reg    <= s_pos_x;
                                    py_reg    <= s_pos_y;
                                    dt_reg    <= s_frame_time;
                                    check_reg <= 1'b0;
                                    if (mode_reg == MODE_FLEE) begin
                                        dx_reg <= 33'(s_pos_x) - 33'(gx_eff);
                                        dy_reg <= 33'(s_pos_y) - 33'(gy_eff);
                                    end else begin
                                        dx_reg <= 33'(gx_eff) - 33'(s_pos_x);
                                        dy_reg <= 33'(gy_eff) - 33'(s_pos_y);
                                    end
                                    go_reg    <= 1'b1;
                                    state_reg <= ST_SQX;
                                end
                            end
                            CMD_SEEK, CMD_FLEE: begin
                                if (!s_follow_live) begin
                                    goal_x_reg <= s_pos_x;
                                    goal_y_reg <= s_pos_y;
                                end
                                track_reg   <= s_follow_live;
                                mode_reg    <= (s_command == CMD_SEEK) ? MODE_SEEK : MODE_FLEE;
                                arrived_reg <= 1'b0;
                            end
                            CMD_ARRIVE: begin
                                goal_x_reg  <= s_pos_x;
                                goal_y_reg  <= s_pos_y;
                                track_reg   <= 1'b0;
                                mode_reg    <= MODE_ARRIVE;
                                arrived_reg <= 1'b0;
                            end
                            CMD_ADD: begin
                                if (wp_we) begin
                                    wp_count_reg <= wp_count_reg + 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                wp_count_reg <= '0;
                                wp_index_reg <= '0;
                            end
                            CMD_PATROL: begin
                                if (wp_count_reg != '0) begin
                                    state_reg <= ST_LOAD0;
                                end
                            end
                            CMD_IDLE: begin
                                mode_reg <= MODE_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
                // first waypoint arrives from the ring
                ST_LOAD0: begin
                    goal_x_reg   <= wp_rdata[63:32];
                    goal_y_reg   <= wp_rdata[31:0];
                    wp_index_reg <= '0;
                    track_reg    <= 1'b0;
                    mode_reg     <= MODE_PATROL;
                    arrived_reg  <= 1'b0;
                    state_reg    <= ST_IDLE;
                end
                // distance: squares, sum, root
                ST_SQX: begin
                    if (ar_done) begin
                        acc_reg   <= ar_result[64:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_SQY;
                    end
                end
                ST_SQY: begin
                    if (ar_done) begin
                        acc_reg   <= acc_reg + ar_result[64:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (ar_done) begin
                        if (!check_reg) begin
                            dist_reg  <= root_dist;
                            state_reg <= ST_DECIDE;
                        end else if (root_dist <= {1'b0, stop_radius_reg}) begin
                            // waypoint reached, move on round the ring
                            wp_index_reg <= idx_next;
                            state_reg    <= ST_WPLOAD;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (mode_reg == MODE_FLEE) begin
                        // too close to tell a direction: flee along +x
                        if (dist_reg < FLEE_MIN_DIST) begin
                            dx_reg   <= $signed(ONE_Q16);
                            dy_reg   <= '0;
                            dist_reg <= ONE_Q16;
                        end
                        go_reg <= 1'b1;
                        if (shape) begin
                            spd_reg   <= move_speed_reg;
                            state_reg <= ST_STEP;
                        end else begin
                            step_reg  <= FLEE_REACH;
                            state_reg <= ST_OFFX_MUL;
                        end
                    end else if (dist_reg <= {1'b0, stop_radius_reg}) begin
                        arrived_reg <= 1'b1;
                        dest_x_reg  <= goal_x_reg;
                        dest_y_reg  <= goal_y_reg;
                        state_reg   <= (mode_reg == MODE_PATROL) ? ST_PSETUP : ST_OUT;
                    end else begin
                        arrived_reg <= 1'b0;
                        if (!shape) begin
                            dest_x_reg <= goal_x_reg;
                            dest_y_reg <= goal_y_reg;
                            state_reg  <= (mode_reg == MODE_PATROL) ? ST_PSETUP : ST_OUT;
                        end else if ((mode_reg == MODE_ARRIVE)
                                     && (dist_reg < {1'b0, arrive_radius_reg})) begin
                            go_reg    <= 1'b1;
                            state_reg <= ST_ARRMUL;
                        end else begin
                            spd_reg   <= move_speed_reg;
                            go_reg    <= 1'b1;
                            state_reg <= ST_STEP;
                        end
                    end
                end
                // arrive slows in proportion to distance
                ST_ARRMUL: begin
                    if (ar_done) begin
                        acc_reg   <= ar_result[64:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_ARRDIV;
                    end
                end
                ST_ARRDIV: begin
                    if (ar_done) begin
                        spd_reg   <= ar_result[31:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_STEP;
                    end
                end
                // step length for this frame
                ST_STEP: begin
                    if (ar_done) begin
                        step_reg <= step_new;
                        if ((mode_reg != MODE_FLEE) && ({1'b0, step_new} >= dist_reg)) begin
                            // overshoot lands on the goal
                            dest_x_reg <= goal_x_reg;
                            dest_y_reg <= goal_y_reg;
                            state_reg  <= (mode_reg == MODE_PATROL) ? ST_PSETUP : ST_OUT;
                        end else begin
                            go_reg    <= 1'b1;
                            state_reg <= ST_OFFX_MUL;
                        end
                    end
                end
                // per-axis offset |d| * step / dist
                ST_OFFX_MUL: begin
                    if (ar_done) begin
                        acc_reg   <= ar_result[64:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_OFFX_DIV;
                    end
                end
                ST_OFFX_DIV: begin
                    if (ar_done) begin
                        dest_x_reg <= sat_move(px_reg, dx_reg[32], ar_result[64:0]);
                        go_reg     <= 1'b1;
                        state_reg  <= ST_OFFY_MUL;
                    end
                end
                ST_OFFY_MUL: begin
                    if (ar_done) begin
                        acc_reg   <= ar_result[64:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_OFFY_DIV;
                    end
                end
                ST_OFFY_DIV: begin
                    if (ar_done) begin
                        dest_y_reg <= sat_move(py_reg, dy_reg[32], ar_result[64:0]);
                        state_reg  <= (mode_reg == MODE_PATROL) ? ST_PSETUP : ST_OUT;
                    end
                end
                // patrol: measure entity to waypoint again
                ST_PSETUP: begin
                    dx_reg    <= 33'(goal_x_reg) - 33'(ex);
                    dy_reg    <= 33'(goal_y_reg) - 33'(ey);
                    check_reg <= 1'b1;
                    go_reg    <= 1'b1;
                    state_reg <= ST_SQX;
                end
                ST_WPLOAD: begin
                    goal_x_reg <= wp_rdata[63:32];
                    goal_y_reg <= wp_rdata[31:0];
                    state_reg  <= ST_OUT;
                end
                // hand the item to the output register once it is free
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_dest_x_reg  <= dest_x_reg;
                        m_dest_y_reg  <= dest_y_reg;
                        m_arrived_reg <= arrived_reg;
                        m_mode_reg    <= mode_reg;
                        m_wp_reg      <= wp_index_reg;
                        m_valid_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dest_x       = m_dest_x_reg;
    assign m_dest_y       = m_dest_y_reg;
    assign m_has_arrived  = m_arrived_reg;
    assign m_current_mode = m_mode_reg;
    assign m_waypoint_now = m_wp_reg;

endmodule

// ===== verif/tb_steering_seek_flee_arrive_patrol_top.sv =====
// testbench for the point-entity steering block: directed and random items
// checked against a predictor kept in the bench; depends on sfap_pkg and the rtl
module tb_steering_seek_flee_arrive_patrol_top;
    import sfap_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               arr;
        logic [2:0]         mode;
        logic [3:0]         wp;
    } steer_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command = CMD_TICK;
    logic signed [31:0] s_pos_x = '0;
    logic signed [31:0] s_pos_y = '0;
    logic signed [31:0] s_live_x = '0;
    logic signed [31:0] s_live_y = '0;
    logic               s_follow_live = 1'b0;
    logic [15:0]        s_frame_time = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_dest_x;
    logic signed [31:0] m_dest_y;
    logic               m_has_arrived;
    logic [2:0]         m_current_mode;
    logic [3:0]         m_waypoint_now;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    steering_seek_flee_arrive_patrol_top u_top (.*);

    // bench copy of registers and steering state
    logic [31:0]        cfg_speed, cfg_stop, cfg_arrive;
    logic [1:0]         cfg_kind;
    logic [2:0]         st_mode;
    logic signed [31:0] st_goal_x, st_goal_y;
    logic               st_track, st_arrived;
    logic signed [31:0] wp_x [MAX_WAYPOINTS];
    logic signed [31:0] wp_y [MAX_WAYPOINTS];
    int unsigned        wp_count, wp_index;

    steer_res_t dest_q [$];
    int  fail_count = 0;
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  ticks_sent = 0;
    int  results_seen = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_cycles = 0;

    // clock and timeout
    initial forever #5 aclk = ~aclk;

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------- predictor arithmetic ----------------
    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // euclidean distance, rooted at a quarter and doubled when the sum of squares wraps
    function automatic logic [63:0] span(longint dx, longint dy);
        logic [63:0] ax, ay, qx, qy, lo;
        ax = mag(dx);
        ay = mag(dy);
        qx = ax * ax;
        qy = ay * ay;
        lo = qx + qy;
        if (lo < qx) return 64'd2 * root64(64'h4000_0000_0000_0000 + (lo >> 2));
        return root64(lo);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] nudge(logic signed [31:0] cur, longint d,
                                                 logic [63:0] stp, logic [63:0] span_len);
        longint off;
        off = longint'((mag(d) * stp) / span_len);
        return sat32(d < 0 ? longint'(cur) - off : longint'(cur) + off);
    endfunction

    function automatic logic [63:0] frame_step(logic [63:0] speed, logic [15:0] dt);
        return (speed * 64'(dt)) >> 16;
    endfunction

    // applies one accepted item to the bench state; returns 1 with a destination
    function automatic bit steer_predict(logic [2:0] cmd, logic signed [31:0] px,
                                         logic signed [31:0] py, logic signed [31:0] lx,
                                         logic signed [31:0] ly, logic fl,
                                         logic [15:0] dt, output steer_res_t r);
        bit shape;
        longint dx, dy;
        logic [63:0] span_len, stp, spd;
        logic signed [31:0] ox, oy, ex, ey;
        shape = (cfg_kind == KIND_SHAPE);
        ox = 0;
        oy = 0;
        r = '{0, 0, 0, 0, 0};
        case (cmd)
            CMD_SEEK, CMD_FLEE: begin
                if (!fl) begin
                    st_goal_x = px;
                    st_goal_y = py;
                end
                st_track = fl;
                st_mode = (cmd == CMD_SEEK) ? MODE_SEEK : MODE_FLEE;
                st_arrived = 0;
                return 0;
            end
            CMD_ARRIVE: begin
                st_goal_x = px;
                st_goal_y = py;
                st_track = 0;
                st_mode = MODE_ARRIVE;
                st_arrived = 0;
                return 0;
            end
            CMD_ADD: begin
                if (wp_count < MAX_WAYPOINTS) begin
                    wp_x[wp_count] = px;
                    wp_y[wp_count] = py;
                    wp_count++;
                end
                return 0;
            end
            CMD_CLEAR: begin
                wp_count = 0;
                wp_index = 0;
                return 0;
            end
            CMD_PATROL: begin
                if (wp_count == 0) return 0;
                wp_index = 0;
                st_goal_x = wp_x[0];
                st_goal_y = wp_y[0];
                st_track = 0;
                st_mode = MODE_PATROL;
                st_arrived = 0;
                return 0;
            end
            CMD_IDLE: begin
                st_mode = MODE_IDLE;
                return 0;
            end
            default: ;
        endcase
        if (st_mode == MODE_IDLE || (cfg_kind != KIND_SPRITE && cfg_kind != KIND_SHAPE))
            return 0;
        if (st_mode == MODE_PATROL && wp_count == 0) return 0;
        if (st_mode > MODE_PATROL) return 0;
        if (st_track) begin
            st_goal_x = lx;
            st_goal_y = ly;
        end
        if (st_mode == MODE_FLEE) begin
            stp = shape ? frame_step(64'(cfg_speed), dt) : 64'(FLEE_REACH);
            dx = longint'(px) - longint'(st_goal_x);
            dy = longint'(py) - longint'(st_goal_y);
            span_len = span(dx, dy);
            // too close to tell a direction: flee along +x
            if (span_len < 64'(FLEE_MIN_DIST)) begin
                dx = 65536;
                dy = 0;
                span_len = 64'(ONE_Q16);
            end
            ox = nudge(px, dx, stp, span_len);
            oy = nudge(py, dy, stp, span_len);
        end else begin
            dx = longint'(st_goal_x) - longint'(px);
            dy = longint'(st_goal_y) - longint'(py);
            span_len = span(dx, dy);
            if (span_len <= 64'(cfg_stop)) begin
                st_arrived = 1;
                ox = st_goal_x;
                oy = st_goal_y;
            end else begin
                st_arrived = 0;
                if (!shape) begin
                    ox = st_goal_x;
                    oy = st_goal_y;
                end else begin
                    spd = 64'(cfg_speed);
                    if (st_mode == MODE_ARRIVE && span_len < 64'(cfg_arrive))
                        spd = (64'(cfg_speed) * span_len) / 64'(cfg_arrive);
                    stp = frame_step(spd, dt);
                    if (stp >= span_len) begin
                        ox = st_goal_x;
                        oy = st_goal_y;
                    end else begin
                        ox = nudge(px, dx, stp, span_len);
                        oy = nudge(py, dy, stp, span_len);
                    end
                end
            end
            if (st_mode == MODE_PATROL) begin
                ex = shape ? ox : px;
                ey = shape ? oy : py;
                if (span(longint'(st_goal_x) - longint'(ex),
                         longint'(st_goal_y) - longint'(ey)) <= 64'(cfg_stop)) begin
                    wp_index = (wp_index + 1) % wp_count;
                    st_goal_x = wp_x[wp_index % MAX_WAYPOINTS];
                    st_goal_y = wp_y[wp_index % MAX_WAYPOINTS];
                end
            end
        end
        r.x = ox;
        r.y = oy;
        r.arr = st_arrived;
        r.mode = st_mode;
        r.wp = wp_index[3:0];
        return 1;
    endfunction

    // ---------------- result side ----------------
    // ready follows the stall rate unless a long hold-off is running
    initial forever begin
        @(posedge aclk);
        if (aresetn && m_valid && m_ready) begin
            steer_res_t e;
            results_seen++;
            if (dest_q.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result x=%h y=%h", m_dest_x, m_dest_y);
            end else begin
                e = dest_q.pop_front();
                if (m_dest_x !== e.x || m_dest_y !== e.y || m_has_arrived !== e.arr ||
                    m_current_mode !== e.mode || m_waypoint_now !== e.wp) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp x=%h y=%h arr=%0d mode=%0d wp=%0d,",
                                  " got x=%h y=%h arr=%0d mode=%0d wp=%0d"},
                                 e.x, e.y, e.arr, e.mode, e.wp, m_dest_x, m_dest_y,
                                 m_has_arrived, m_current_mode, m_waypoint_now);
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------- drive side ----------------
    task automatic send_item(logic [2:0] cmd, logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] lx, logic signed [31:0] ly, logic fl,
                             logic [15:0] dt);
        steer_res_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_pos_x <= px;
        s_pos_y <= py;
        s_live_x <= lx;
        s_live_y <= ly;
        s_follow_live <= fl;
        s_frame_time <= dt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (cmd == CMD_TICK) ticks_sent++;
        if (steer_predict(cmd, px, py, lx, ly, fl, dt, r)) dest_q.push_back(r);
    endtask

    // lower valid, let every expected item arrive, then allow for a silent tick
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (dest_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // setup cycle, access cycle, then a quiet bus before the bench copy updates
    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_SPEED:  cfg_speed = val;
            REG_STOP:   cfg_stop = val;
            REG_ARRIVE: cfg_arrive = val;
            default:    cfg_kind = val[1:0];
        endcase
    endtask

    task automatic set_regs(logic [31:0] spd, logic [31:0] stp, logic [31:0] arr,
                            logic [1:0] kind);
        apb_write(REG_SPEED, spd);
        apb_write(REG_STOP, stp);
        apb_write(REG_ARRIVE, arr);
        apb_write(REG_KIND, {30'd0, kind});
    endtask

    function automatic logic signed [31:0] q16(int v);
        return v <<< 16;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 0;
            3:       return $signed($urandom_range(0, 1 << 25)) - (1 <<< 24);
            default: return $urandom;
        endcase
    endfunction

    // point around c, wrapping at the 32 bit range
    function automatic logic signed [31:0] near(logic signed [31:0] c);
        int spread;
        case ($urandom_range(3))
            0:       spread = 0;
            1:       spread = 1 << 8;
            2:       spread = 1 << 16;
            default: spread = 1 << 22;
        endcase
        return c + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // random part: mostly well-formed mode changes followed by ticks near the goal
    task automatic random_items(int count);
        int start, k, n;
        logic [2:0] cmd;
        logic signed [31:0] gx, gy, px, py;
        start = items_sent;
        while (items_sent - start < count) begin
            case ($urandom_range(9))
                3, 4: begin
                    send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(1), $urandom);
                    n = $urandom_range(1, 18);
                    gx = rand_coord();
                    gy = rand_coord();
                    for (k = 0; k < n; k++) begin
                        send_item(CMD_ADD, gx, gy, $urandom, $urandom, $urandom_range(1),
                                  $urandom);
                        gx = near(gx);
                        gy = near(gy);
                    end
                    send_item(CMD_PATROL, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(1), $urandom);
                    n = $urandom_range(2, 12);
                    for (k = 0; k < n; k++)
                        send_item(CMD_TICK, near(st_goal_x), near(st_goal_y), $urandom,
                                  $urandom, $urandom_range(1), $urandom);
                end
                5: send_item($urandom_range(7), $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(1), $urandom);
                6: send_item(CMD_TICK, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), $urandom_range(1), $urandom);
                7: send_item($urandom_range(0, 1) ? CMD_IDLE : CMD_CLEAR, $urandom,
                             $urandom, $urandom, $urandom, $urandom_range(1), $urandom);
                default: begin
                    case ($urandom_range(2))
                        0:       cmd = CMD_SEEK;
                        1:       cmd = CMD_FLEE;
                        default: cmd = CMD_ARRIVE;
                    endcase
                    gx = rand_coord();
                    gy = rand_coord();
                    send_item(cmd, gx, gy, $urandom, $urandom, $urandom_range(1), $urandom);
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++) begin
                        px = $urandom_range(3) == 0 ? rand_coord() : near(st_goal_x);
                        py = $urandom_range(3) == 0 ? rand_coord() : near(st_goal_y);
                        send_item(CMD_TICK, px, py, near(st_goal_x), near(st_goal_y),
                                  $urandom_range(1), $urandom);
                    end
                end
            endcase
        end
    endtask

    function automatic logic [31:0] rand_speed();
        return $urandom_range(0, 1 << 26);
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        int k;
        idle_pct = 0;
        stall_pct = 0;
        set_regs(32'd6553600, 32'd65536, 32'd6553600, KIND_SHAPE);
        // tick while idle gives nothing
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'hffff);
        // seek: one step short of the goal, then inside the stop radius
        send_item(CMD_SEEK, q16(100), 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'hffff);
        send_item(CMD_TICK, q16(100) - 100, 0, 0, 0, 0, 16'h0000);
        // arrive with slow-down
        send_item(CMD_ARRIVE, q16(50), q16(50), 0, 0, 1, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'h8000);
        // flee sitting on the goal
        send_item(CMD_FLEE, 0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 10, -10, 0, 0, 0, 16'hffff);
        // flee from a live target at the far corner, result saturates
        send_item(CMD_FLEE, 0, 0, 0, 0, 1, 0);
        send_item(CMD_TICK, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7fff_ffff, 0, 16'hffff);
        send_item(CMD_SEEK, 0, 0, 0, 0, 1, 0);
        send_item(CMD_TICK, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 0, 16'hffff);
        // empty ring: start patrol is ignored
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_item(CMD_PATROL, 0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'h1000);
        // full ring: the seventeenth add is dropped
        for (k = 0; k < MAX_WAYPOINTS + 1; k++)
            send_item(CMD_ADD, q16(k * 3), q16(-k), 0, 0, 0, 0);
        send_item(CMD_PATROL, 0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'hffff);
        // patrol wrap on a two point ring
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_item(CMD_ADD, q16(5), q16(5), 0, 0, 0, 0);
        send_item(CMD_ADD, q16(-5), q16(5), 0, 0, 0, 0);
        send_item(CMD_PATROL, 0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, q16(5), q16(5), 0, 0, 0, 16'h0100);
        send_item(CMD_TICK, q16(-5), q16(5), 0, 0, 0, 16'h0100);
        send_item(CMD_IDLE, 0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'hffff);
        wait_drained();
        // sprite kind: flee near zero uses the lookahead
        set_regs(32'hffff_ffff, 32'd0, 32'hffff_ffff, KIND_SPRITE);
        send_item(CMD_FLEE, q16(1), q16(1), 0, 0, 0, 0);
        send_item(CMD_TICK, q16(1), q16(1), 0, 0, 0, 16'hffff);
        send_item(CMD_SEEK, q16(7), q16(7), 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'hffff);
        wait_drained();
        // kinds 0 and 3 attach nothing
        apb_write(REG_KIND, 32'd0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'hffff);
        wait_drained();
        apb_write(REG_KIND, 32'd3);
        send_item(CMD_TICK, 0, 0, 0, 0, 0, 16'hffff);
        wait_drained();
    endtask

    task automatic test_random_steady();
        idle_pct = 0;
        stall_pct = 0;
        set_regs(rand_speed(), $urandom_range(0, 1 << 18), $urandom_range(1, 1 << 26),
                 KIND_SHAPE);
        random_items(160);
        wait_drained();
    endtask

    task automatic test_random_sender_gaps();
        idle_pct = 86;
        stall_pct = 0;
        set_regs(rand_speed(), $urandom_range(0, 1 << 18), $urandom_range(1, 1 << 26),
                 KIND_SPRITE);
        random_items(160);
        wait_drained();
    endtask

    task automatic test_random_receiver_stall();
        idle_pct = 0;
        stall_pct = 86;
        set_regs(32'hffff_ffff, 32'd0, 32'hffff_ffff, KIND_SHAPE);
        random_items(160);
        wait_drained();
    endtask

    task automatic test_random_both_idle();
        idle_pct = 35;
        stall_pct = 35;
        set_regs(32'd0, 32'hffff_ffff, 32'd0, KIND_SHAPE);
        random_items(80);
        wait_drained();
        set_regs(rand_speed(), $urandom_range(0, 1 << 20), $urandom_range(1, 1 << 28),
                 $urandom_range(1, 2));
        random_items(80);
        wait_drained();
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        set_regs(rand_speed(), $urandom_range(0, 1 << 18), $urandom_range(1, 1 << 26),
                 KIND_SHAPE);
        hold_cycles = 3000;
        random_items(80);
        wait_drained();
    endtask

    initial begin
        cfg_speed = 32'd6553600;
        cfg_stop = 32'd65536;
        cfg_arrive = 32'd6553600;
        cfg_kind = 2'd0;
        st_mode = MODE_IDLE;
        st_goal_x = 0;
        st_goal_y = 0;
        st_track = 0;
        st_arrived = 0;
        wp_count = 0;
        wp_index = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_steady();
        test_random_sender_gaps();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();
        $display("items sent %0d (ticks %0d), destinations checked %0d, mismatches %0d",
                 items_sent, ticks_sent, results_seen, mismatch_count);
        $display("covered seek, arrive, flee, patrol rings, idle ticks and register extremes");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
